// File: sv/w3se_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w3se_pkg: shared constants for the 3x3 window sum extreme search unit
// Register indexes, register widths and reset values, result queue sizing.
// ----------------------------------------------------------------------------
package w3se_pkg;

   // configuration register file
   localparam int CFG_BITS       = 7;
   localparam int CSR_INDEX_BITS = 4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_COUNT = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COL_COUNT = CSR_INDEX_BITS'(1);
   localparam logic [CFG_BITS-1:0]       CFG_RESET     = CFG_BITS'(64);

   // result queue: one slot per possible result in flight
   localparam int OUT_DEPTH    = 4;
   localparam int OUT_PTR_BITS = 2;
   localparam int OUT_CNT_BITS = 3;

endpackage

// File: sv/window3x3_sum_extreme_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window3x3_sum_extreme_search_unit: 3x3 box sum max/min search
// Streams a matrix in raster order, sums every full 3x3 window and reports
// the largest and smallest sum with the top-left corner of the first window
// reaching it, one result per matrix.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req     | in  | req_tvalid/req_tready | req_tdata: element
//  rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata: found, max_sum, max_row,
//          |     |                       |   max_col, min_sum, min_row, min_col
//  csr     | in  | csr_valid/csr_ready   | csr_index, csr_data
//
// one element per cycle while req_tready is high; the line buffer
// read-modify-write and the nine-term sum pass the stage 1 and stage 2
// registers, then the result enters the result queue before it is offered.
// reset is synchronous; line buffer contents are not cleared, every entry is
// rewritten during the first two rows of a matrix before a window uses it.
// req_tready drops only when four results are owed and not yet taken.
// ----------------------------------------------------------------------------
module window3x3_sum_extreme_search_unit
   import w3se_pkg::*;
#(
   parameter int MAX_DIM   = 64,
   parameter int ELEM_BITS = 8,
   localparam int POS_BITS = $clog2(MAX_DIM),
   localparam int SUM_BITS = ELEM_BITS + 4,
   localparam int IN_BITS  = ((ELEM_BITS + 7) / 8) * 8,
   localparam int RES_BITS = 1 + 2 * (SUM_BITS + 2 * POS_BITS),
   localparam int OUT_BITS = ((RES_BITS + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // input stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [IN_BITS-1:0]        req_tdata,   // element
   // result stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [OUT_BITS-1:0]       rsp_tdata,   // found, max_sum, max_row,
                                                  // max_col, min_sum, min_row,
                                                  // min_col, zero pad
   // configuration writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_data
);

   localparam int DIM_BITS = (POS_BITS + 1 > CFG_BITS) ? POS_BITS + 1 : CFG_BITS;

   // last valid index for a register value: 0 acts as 1, large values saturate
   function automatic logic [POS_BITS-1:0] last_index(input logic [CFG_BITS-1:0] v);
      logic [DIM_BITS-1:0] ext;
      logic [DIM_BITS-1:0] lim;
      logic [DIM_BITS-1:0] res;
      ext = DIM_BITS'(v);
      lim = DIM_BITS'(MAX_DIM);
      if (ext == '0) begin
         res = '0;
      end else if (ext > lim) begin
         res = lim - DIM_BITS'(1);
      end else begin
         res = ext - DIM_BITS'(1);
      end
      return res[POS_BITS-1:0];
   endfunction

   // configuration registers, held as last row and column index
   logic [POS_BITS-1:0] row_last_ff, row_last_in;
   logic [POS_BITS-1:0] col_last_ff, col_last_in;
   logic                cfg_restart;

   assign csr_ready = 1'b1;

   always_comb begin
      row_last_in = row_last_ff;
      col_last_in = col_last_ff;
      cfg_restart = 1'b0;
      if (csr_valid) begin
         case (csr_index)
            CSR_ROW_COUNT: begin
               row_last_in = last_index(csr_data);
               cfg_restart = 1'b1;
            end
            CSR_COL_COUNT: begin
               col_last_in = last_index(csr_data);
               cfg_restart = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_last_ff <= last_index(CFG_RESET);
         col_last_ff <= last_index(CFG_RESET);
      end else begin
         row_last_ff <= row_last_in;
         col_last_ff <= col_last_in;
      end
   end

   // input transfer and raster position
   logic                 req_xfer;
   logic                 end_of_row;
   logic                 end_of_frame;
   logic                 is_window;
   logic [ELEM_BITS-1:0] elem;
   logic [POS_BITS-1:0]  cur_row_ff, cur_row_in;
   logic [POS_BITS-1:0]  cur_col_ff, cur_col_in;

   assign req_xfer     = req_tvalid && req_tready;
   assign elem         = req_tdata[ELEM_BITS-1:0];
   assign end_of_row   = (cur_col_ff == col_last_ff);
   assign end_of_frame = end_of_row && (cur_row_ff == row_last_ff);
   assign is_window    = (cur_row_ff >= POS_BITS'(2)) && (cur_col_ff >= POS_BITS'(2));

   always_comb begin
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      if (cfg_restart) begin
         cur_row_in = '0;
         cur_col_in = '0;
      end else if (req_xfer) begin
         if (end_of_row) begin
            cur_col_in = '0;
            cur_row_in = end_of_frame ? '0 : cur_row_ff + POS_BITS'(1);
         end else begin
            cur_col_in = cur_col_ff + POS_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff <= '0;
         cur_col_ff <= '0;
      end else begin
         cur_row_ff <= cur_row_in;
         cur_col_ff <= cur_col_in;
      end
   end

   // stage 1 registers: element, column and window position
   logic                 s1_valid_ff;
   logic                 s1_win_ff;
   logic                 s1_last_ff;
   logic [ELEM_BITS-1:0] s1_elem_ff;
   logic [POS_BITS-1:0]  s1_col_ff;
   logic [POS_BITS-1:0]  s1_prow_ff;
   logic [POS_BITS-1:0]  s1_pcol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_xfer;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_win_ff  <= is_window;
         s1_last_ff <= end_of_frame;
         s1_elem_ff <= elem;
         s1_col_ff  <= cur_col_ff;
         s1_prow_ff <= cur_row_ff - POS_BITS'(2);
         s1_pcol_ff <= cur_col_ff - POS_BITS'(2);
      end
   end

   // line buffer: one entry per column, older row in the upper half
   logic [2*ELEM_BITS-1:0] line_mem [MAX_DIM];
   logic [2*ELEM_BITS-1:0] rd_data_ff;
   logic [2*ELEM_BITS-1:0] byp_data_ff;
   logic                   byp_ff;
   logic [2*ELEM_BITS-1:0] line_data;
   logic [2*ELEM_BITS-1:0] wr_data;

   assign line_data = byp_ff ? byp_data_ff : rd_data_ff;
   assign wr_data   = {line_data[ELEM_BITS-1:0], s1_elem_ff};

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rd_data_ff <= line_mem[cur_col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         line_mem[s1_col_ff] <= wr_data;
      end
   end

   // forward the write when the next element reads the same column
   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (req_xfer) begin
         byp_ff <= s1_valid_ff && (s1_col_ff == cur_col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         byp_data_ff <= wr_data;
      end
   end

   // 3x3 window shift and nine-term sum
   logic [ELEM_BITS-1:0] win_ff [9];
   logic [ELEM_BITS-1:0] win_in [9];
   logic [SUM_BITS-1:0]  row_sum [3];
   logic [SUM_BITS-1:0]  win_sum;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[k*3+0] = win_ff[k*3+1];
         win_in[k*3+1] = win_ff[k*3+2];
      end
      win_in[2] = line_data[2*ELEM_BITS-1:ELEM_BITS];
      win_in[5] = line_data[ELEM_BITS-1:0];
      win_in[8] = s1_elem_ff;
      for (int k = 0; k < 3; k++) begin
         row_sum[k] = SUM_BITS'(win_in[k*3+0]) + SUM_BITS'(win_in[k*3+1])
                    + SUM_BITS'(win_in[k*3+2]);
      end
      win_sum = row_sum[0] + row_sum[1] + row_sum[2];
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         win_ff <= win_in;
      end
   end

   // stage 2 registers
   logic                s2_valid_ff;
   logic                s2_win_ff;
   logic                s2_last_ff;
   logic [SUM_BITS-1:0] s2_sum_ff;
   logic [POS_BITS-1:0] s2_prow_ff;
   logic [POS_BITS-1:0] s2_pcol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_win_ff  <= s1_win_ff;
         s2_last_ff <= s1_last_ff;
         s2_sum_ff  <= win_sum;
         s2_prow_ff <= s1_prow_ff;
         s2_pcol_ff <= s1_pcol_ff;
      end
   end

   // running extremes, strict compares keep the first window on ties
   logic                any_ff, any_in;
   logic [SUM_BITS-1:0] max_sum_ff, max_sum_in;
   logic [POS_BITS-1:0] max_row_ff, max_row_in;
   logic [POS_BITS-1:0] max_col_ff, max_col_in;
   logic [SUM_BITS-1:0] min_sum_ff, min_sum_in;
   logic [POS_BITS-1:0] min_row_ff, min_row_in;
   logic [POS_BITS-1:0] min_col_ff, min_col_in;
   logic                hit;
   logic                push;
   logic [RES_BITS-1:0] result;

   assign hit  = s2_valid_ff && s2_win_ff;
   assign push = s2_valid_ff && s2_last_ff;

   always_comb begin
      any_in     = any_ff || hit;
      max_sum_in = max_sum_ff;
      max_row_in = max_row_ff;
      max_col_in = max_col_ff;
      min_sum_in = min_sum_ff;
      min_row_in = min_row_ff;
      min_col_in = min_col_ff;
      if (hit && (!any_ff || s2_sum_ff > max_sum_ff)) begin
         max_sum_in = s2_sum_ff;
         max_row_in = s2_prow_ff;
         max_col_in = s2_pcol_ff;
      end
      if (hit && (!any_ff || s2_sum_ff < min_sum_ff)) begin
         min_sum_in = s2_sum_ff;
         min_row_in = s2_prow_ff;
         min_col_in = s2_pcol_ff;
      end
      if (any_in) begin
         result = {min_col_in, min_row_in, min_sum_in,
                   max_col_in, max_row_in, max_sum_in, 1'b1};
      end else begin
         result = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_restart || push) begin
         any_ff     <= 1'b0;
         max_sum_ff <= '0;
         max_row_ff <= '0;
         max_col_ff <= '0;
         min_sum_ff <= '0;
         min_row_ff <= '0;
         min_col_ff <= '0;
      end else begin
         any_ff     <= any_in;
         max_sum_ff <= max_sum_in;
         max_row_ff <= max_row_in;
         max_col_ff <= max_col_in;
         min_sum_ff <= min_sum_in;
         min_row_ff <= min_row_in;
         min_col_ff <= min_col_in;
      end
   end

   // result queue; a slot is reserved when the last element is taken
   logic [RES_BITS-1:0]     out_q_ff [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0] wr_ptr_ff;
   logic [OUT_PTR_BITS-1:0] rd_ptr_ff;
   logic [OUT_CNT_BITS-1:0] fill_ff, fill_in;
   logic [OUT_CNT_BITS-1:0] credit_ff, credit_in;
   logic                    pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (fill_ff != '0);
   assign rsp_tdata  = OUT_BITS'(out_q_ff[rd_ptr_ff]);
   assign req_tready = (credit_ff < OUT_CNT_BITS'(OUT_DEPTH));

   always_comb begin
      fill_in   = fill_ff + OUT_CNT_BITS'(push) - OUT_CNT_BITS'(pop);
      credit_in = credit_ff + OUT_CNT_BITS'(req_xfer && end_of_frame)
                - OUT_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         credit_ff <= '0;
      end else begin
         fill_ff   <= fill_in;
         credit_ff <= credit_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + OUT_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + OUT_PTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_q_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

// File: sv/w3se_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w3se_checker: port-level checks for the 3x3 window sum extreme search unit
// Result hold under stall, reset behavior and consistency of result fields.
// ----------------------------------------------------------------------------
module w3se_checker
   import w3se_pkg::*;
#(
   parameter int MAX_DIM   = 64,
   parameter int ELEM_BITS = 8,
   localparam int POS_BITS = $clog2(MAX_DIM),
   localparam int SUM_BITS = ELEM_BITS + 4,
   localparam int RES_BITS = 1 + 2 * (SUM_BITS + 2 * POS_BITS),
   localparam int OUT_BITS = ((RES_BITS + 7) / 8) * 8
) (
   input logic                clock,
   input logic                reset,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [OUT_BITS-1:0] rsp_tdata   // found, max_sum, max_row, max_col,
                                          // min_sum, min_row, min_col, pad
);

   localparam int MAXS_LO = 1;
   localparam int MAXR_LO = MAXS_LO + SUM_BITS;
   localparam int MAXC_LO = MAXR_LO + POS_BITS;
   localparam int MINS_LO = MAXC_LO + POS_BITS;
   localparam int MINR_LO = MINS_LO + SUM_BITS;
   localparam int MINC_LO = MINR_LO + POS_BITS;
   localparam logic [POS_BITS-1:0] TOP_POS = POS_BITS'(MAX_DIM - 3);

   logic                found;
   logic [SUM_BITS-1:0] max_sum;
   logic [SUM_BITS-1:0] min_sum;
   logic [POS_BITS-1:0] max_row;
   logic [POS_BITS-1:0] min_row;
   logic [RES_BITS-1:0] res_body;

   assign found    = rsp_tdata[0];
   assign max_sum  = rsp_tdata[MAXR_LO-1:MAXS_LO];
   assign max_row  = rsp_tdata[MAXC_LO-1:MAXR_LO];
   assign min_sum  = rsp_tdata[MINR_LO-1:MINS_LO];
   assign min_row  = rsp_tdata[MINC_LO-1:MINR_LO];
   assign res_body = rsp_tdata[RES_BITS-1:0];

   // a stalled result keeps its valid and its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // a matrix without a full window reports all-zero fields
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !found |-> res_body == '0)
      else $error("non-zero fields without a window");

   // extremes are ordered and their corner rows are at most MAX_DIM - 3
   a_found_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && found |-> min_sum <= max_sum && max_row <= TOP_POS
                              && min_row <= TOP_POS)
      else $error("inconsistent extreme fields");

endmodule

bind window3x3_sum_extreme_search_unit w3se_checker #(
   .MAX_DIM  (MAX_DIM),
   .ELEM_BITS(ELEM_BITS)
) u_w3se_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

// File: tb/tb_window3x3_sum_extreme_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_window3x3_sum_extreme_search_unit: self-checking bench for the 3x3 search
// Streams matrices of many shapes through the unit. A behavioral copy of the
// window search predicts each matrix result. The unit's results are compared
// field by field in arrival order. A short directed plan covers the extremes,
// the dimension clamps and abandoning a matrix. Random matrices follow, with
// random idling on both streams, a no-idle stretch and a long result stall.
// ----------------------------------------------------------------------------
module tb_window3x3_sum_extreme_search_unit;
   import w3se_pkg::*;

   localparam int MAX_DIM       = 64;
   localparam int IDLE_PCT      = 34;
   localparam int SETTLE_CYCLES = 8;     // covers the pipeline depth
   localparam int DRAIN_CYCLES  = 16;
   localparam int HOLD_CYCLES   = 300;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PIXEL_TARGET  = 1550;
   localparam int PLAN_ROWS     = 16;
   localparam int LAST_PHASE    = 8;     // phases with fixed roles run first
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = CSR_INDEX_BITS'(15);

   // result fields, most significant first; found sits in bit 0
   typedef struct packed {
      logic [6:0]  pad;
      logic [5:0]  min_col;
      logic [5:0]  min_row;
      logic [11:0] min_sum;
      logic [5:0]  max_col;
      logic [5:0]  max_row;
      logic [11:0] max_sum;
      logic        found;
   } result_type;

   typedef enum logic {DO_WRITE, DO_PIXELS} plan_kind_type;

   typedef struct {
      plan_kind_type kind;
      logic [3:0]    index;
      logic [7:0]    value;
      int            reps;
      bit            typed;
      result_type    result;
   } plan_row_type;

   localparam result_type NO_WINDOW = '0;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = '0;   // element
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [$bits(result_type)-1:0] rsp_tdata;     // found, max_sum, max_row,
                                                 // max_col, min_sum, min_row,
                                                 // min_col, zero pad
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CFG_BITS-1:0]       csr_data   = '0;

   // sideband that travels with an element whose result is typed in the plan
   logic       fixed_en  = 1'b0;
   result_type fixed_val = '0;

   logic steady   = 1'b0;
   logic stall_go = 1'b0;
   logic rsp_hold = 1'b0;

   // behavioral copy of the search state
   logic [6:0] cfg_rows;
   logic [6:0] cfg_cols;
   logic [7:0] line_buf [2][MAX_DIM];
   logic [7:0] win [9];
   int         scan_row;
   int         scan_col;
   int         top_sum, top_r, top_c;
   int         low_sum, low_r, low_c;
   bit         seen_window;

   result_type pending_results [$];
   int         mismatches     = 0;
   int         results_seen   = 0;
   int         pixels_sent    = 0;
   int         writes_done    = 0;
   int         quiet_cycles   = 0;

   plan_row_type directed [PLAN_ROWS];

   window3x3_sum_extreme_search_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // dimension as the unit uses it
   function automatic int eff_dim(input logic [6:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   // one full window result with every element equal
   function automatic result_type flat_result(input logic [11:0] sum);
      result_type r;
      r         = '0;
      r.found   = 1'b1;
      r.max_sum = sum;
      r.min_sum = sum;
      return r;
   endfunction

   task automatic clear_search();
      scan_row    = 0;
      scan_col    = 0;
      top_sum     = 0;
      top_r       = 0;
      top_c       = 0;
      low_sum     = 0;
      low_r       = 0;
      low_c       = 0;
      seen_window = 1'b0;
   endtask

   task automatic apply_write(input logic [3:0] idx, input logic [6:0] data);
      if (idx == CSR_ROW_COUNT) cfg_rows = data;
      else if (idx == CSR_COL_COUNT) cfg_cols = data;
      else return;
      clear_search();
   endtask

   // advance the window by one element, report the matrix result at its end
   task automatic track_window_extremes(input logic [7:0] x, output bit done,
                                        output result_type res);
      int rows, cols, c, sum;
      rows = eff_dim(cfg_rows);
      cols = eff_dim(cfg_cols);
      c    = (scan_col >= MAX_DIM) ? MAX_DIM - 1 : scan_col;
      for (int k = 0; k < 3; k++) begin
         win[k*3]   = win[k*3+1];
         win[k*3+1] = win[k*3+2];
      end
      win[2]         = line_buf[0][c];
      win[5]         = line_buf[1][c];
      win[8]         = x;
      line_buf[0][c] = line_buf[1][c];
      line_buf[1][c] = x;
      done = 1'b0;
      res  = '0;
      // full window: strict compares keep the first one in scan order
      if (scan_row >= 2 && scan_col >= 2) begin
         sum = 0;
         for (int k = 0; k < 9; k++) sum += int'(win[k]);
         if (!seen_window || sum > top_sum) begin
            top_sum = sum;
            top_r   = scan_row - 2;
            top_c   = scan_col - 2;
         end
         if (!seen_window || sum < low_sum) begin
            low_sum = sum;
            low_r   = scan_row - 2;
            low_c   = scan_col - 2;
         end
         seen_window = 1'b1;
      end
      // raster position, result after the last element
      if (scan_col + 1 >= cols) begin
         scan_col = 0;
         if (scan_row + 1 >= rows) begin
            done = 1'b1;
            if (seen_window) begin
               res.found   = 1'b1;
               res.max_sum = 12'(top_sum);
               res.max_row = 6'(top_r);
               res.max_col = 6'(top_c);
               res.min_sum = 12'(low_sum);
               res.min_row = 6'(low_r);
               res.min_col = 6'(low_c);
            end
            clear_search();
         end else begin
            scan_row++;
         end
      end else begin
         scan_col++;
      end
   endtask

   // offer one element, idling first at random
   task automatic send_element(input logic [7:0] x, input bit typed,
                               input result_type fixed);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      fixed_en   <= typed;
      fixed_val  <= fixed;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
   endtask

   // register write once every owed result has come and the pipeline is empty
   task automatic write_reg(input logic [3:0] idx, input logic [6:0] data);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      writes_done++;
   endtask

   // elements of one content style: full range, two levels, tiny range, flat
   task automatic stream_pixels(input int n, input int style);
      logic [7:0] level, x;
      level = 8'($urandom_range(255));
      for (int i = 0; i < n; i++) begin
         case (style)
            0:       x = 8'($urandom_range(255));
            1:       x = $urandom_range(1) ? 8'hFF : 8'h00;
            2:       x = 8'($urandom_range(2));
            default: x = level;
         endcase
         send_element(x, 1'b0, NO_WINDOW);
      end
   endtask

   // result stream ready: random, steady, or held off
   always @(posedge clock) begin
      rsp_tready <= rsp_hold ? 1'b0 : (steady || $urandom_range(99) >= IDLE_PCT);
   end

   // long result stall, counted here once the sender asks for it
   initial begin
      while (!stall_go) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // transfers on all three channels: predict, then check
   always @(posedge clock) begin : monitor
      bit         done;
      result_type res, want, got;
      if (!reset) begin
         quiet_cycles++;
         if (csr_valid && csr_ready) begin
            apply_write(csr_index, csr_data);
            quiet_cycles = 0;
         end
         if (req_tvalid && req_tready) begin
            track_window_extremes(req_tdata, done, res);
            if (done) pending_results.push_back(fixed_en ? fixed_val : res);
            quiet_cycles = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            quiet_cycles = 0;
            results_seen++;
            got = rsp_tdata;
            if (pending_results.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result at %0t: %h", $time, got);
               mismatches++;
            end else begin
               want = pending_results.pop_front();
               if (got.found !== want.found || got.max_sum !== want.max_sum ||
                   got.max_row !== want.max_row || got.max_col !== want.max_col ||
                   got.min_sum !== want.min_sum || got.min_row !== want.min_row ||
                   got.min_col !== want.min_col || got.pad !== want.pad) begin
                  if (mismatches < 10) begin
                     $display("mismatch at %0t: expected found=%0d max=%0d@(%0d,%0d)",
                              $time, want.found, want.max_sum, want.max_row,
                              want.max_col);
                     $display("   expected min=%0d@(%0d,%0d) pad=%0h",
                              want.min_sum, want.min_row, want.min_col, want.pad);
                     $display("   actual   found=%0d max=%0d@(%0d,%0d)",
                              got.found, got.max_sum, got.max_row, got.max_col);
                     $display("   actual   min=%0d@(%0d,%0d) pad=%0h",
                              got.min_sum, got.min_row, got.min_col, got.pad);
                  end
                  mismatches++;
               end
            end
         end
      end
   end

   // watchdog: too long with no transfer anywhere
   initial begin
      while (reset || quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   // stimulus
   initial begin
      logic [6:0] r, c;
      int         rc, matrices, phase;

      cfg_rows = CFG_RESET;
      cfg_cols = CFG_RESET;
      for (int i = 0; i < MAX_DIM; i++) begin
         line_buf[0][i] = '0;
         line_buf[1][i] = '0;
      end
      for (int k = 0; k < 9; k++) win[k] = '0;
      clear_search();

      // directed plan: single elements, flat 3x3 extremes, clamps, abandon
      directed[0]  = '{DO_WRITE,  CSR_ROW_COUNT, 8'd1,   1, 1'b0, NO_WINDOW};
      directed[1]  = '{DO_WRITE,  CSR_COL_COUNT, 8'd1,   1, 1'b0, NO_WINDOW};
      directed[2]  = '{DO_PIXELS, CSR_UNUSED,    8'hFF,  1, 1'b1, NO_WINDOW};
      directed[3]  = '{DO_PIXELS, CSR_UNUSED,    8'h00,  1, 1'b1, NO_WINDOW};
      directed[4]  = '{DO_WRITE,  CSR_ROW_COUNT, 8'd3,   1, 1'b0, NO_WINDOW};
      directed[5]  = '{DO_WRITE,  CSR_COL_COUNT, 8'd3,   1, 1'b0, NO_WINDOW};
      directed[6]  = '{DO_PIXELS, CSR_UNUSED,    8'hFF,  9, 1'b1, flat_result(12'd2295)};
      directed[7]  = '{DO_PIXELS, CSR_UNUSED,    8'h00,  9, 1'b1, flat_result(12'd0)};
      // zero rows count as one row
      directed[8]  = '{DO_WRITE,  CSR_ROW_COUNT, 8'd0,   1, 1'b0, NO_WINDOW};
      directed[9]  = '{DO_WRITE,  CSR_COL_COUNT, 8'd2,   1, 1'b0, NO_WINDOW};
      directed[10] = '{DO_PIXELS, CSR_UNUSED,    8'h5A,  2, 1'b1, NO_WINDOW};
      // write to an unused index leaves the shape alone
      directed[11] = '{DO_WRITE,  CSR_UNUSED,    8'h7F,  1, 1'b0, NO_WINDOW};
      directed[12] = '{DO_PIXELS, CSR_UNUSED,    8'hA5,  2, 1'b1, NO_WINDOW};
      // partial matrix, then a write abandons it
      directed[13] = '{DO_WRITE,  CSR_ROW_COUNT, 8'd3,   1, 1'b0, NO_WINDOW};
      directed[14] = '{DO_PIXELS, CSR_UNUSED,    8'h33,  1, 1'b0, NO_WINDOW};
      directed[15] = '{DO_WRITE,  CSR_COL_COUNT, 8'd3,   1, 1'b0, NO_WINDOW};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         if (directed[i].kind == DO_WRITE) begin
            write_reg(directed[i].index, directed[i].value[6:0]);
         end else begin
            for (int k = 0; k < directed[i].reps; k++)
               send_element(directed[i].value,
                            directed[i].typed && k == directed[i].reps - 1,
                            directed[i].result);
         end
      end

      // random phases: forced extreme shapes first, then mostly small shapes
      phase = 0;
      while (pixels_sent < PIXEL_TARGET || phase < LAST_PHASE) begin
         case (phase)
            0: begin r = 7'd64;  c = 7'd3;   end
            1: begin r = 7'd3;   c = 7'd127; end
            2: begin r = 7'd65;  c = 7'd2;   end
            3: begin r = 7'd0;   c = 7'd0;   end
            5: begin r = 7'd1;   c = 7'd1;   end
            default: begin
               case ($urandom_range(9))
                  0:       r = 7'd0;
                  1:       r = 7'd64;
                  2:       r = 7'($urandom_range(65, 127));
                  3:       r = 7'd3;
                  default: r = 7'($urandom_range(1, 10));
               endcase
               case ($urandom_range(9))
                  0:       c = 7'd0;
                  1:       c = 7'd64;
                  2:       c = 7'($urandom_range(65, 127));
                  3:       c = 7'd3;
                  default: c = 7'($urandom_range(1, 10));
               endcase
               if (eff_dim(r) * eff_dim(c) > 256) c = 7'($urandom_range(1, 4));
            end
         endcase
         rc = eff_dim(r) * eff_dim(c);

         if ($urandom_range(1)) begin
            write_reg(CSR_ROW_COUNT, r);
            write_reg(CSR_COL_COUNT, c);
         end else begin
            write_reg(CSR_COL_COUNT, c);
            write_reg(CSR_ROW_COUNT, r);
         end

         // no idling on either side for one phase
         if (phase == 6) steady <= 1'b1;
         if (phase == 7) steady <= 1'b0;
         // one element per result while the result side is held off
         if (phase == 5) stall_go <= 1'b1;

         // large forced shapes get one matrix each
         matrices = (phase == 5) ? 40 : (phase == 6) ? 8 :
                    (phase < 3) ? 1 : $urandom_range(1, 4);
         repeat (matrices) stream_pixels(rc, $urandom_range(3));
         if (rc > 1 && $urandom_range(4) == 0)
            stream_pixels($urandom_range(1, rc - 1), $urandom_range(3));
         phase++;
      end

      // drain
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d elements over %0d phases, %0d register writes",
               pixels_sent, phase, writes_done);
      $display("%0d matrix results compared, %0d mismatches",
               results_seen, mismatches + pending_results.size());
      if (mismatches == 0 && pending_results.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
